### src/wrss_pkg.sv
// Shared types, constants and helper functions of the work range stealing scheduler.
`default_nettype none

package wrss_pkg;

    localparam int COL_W = 13;
    localparam int WID_W = 4;
    localparam int OPC_W = 2;
    localparam int CFG_ADDR_W = 2;

    // Size of the range table; worker ids and the worker count are WID_W bits wide.
    localparam int MAX_WORKERS = 8;

    localparam logic [COL_W-1:0] MAX_COLUMNS = 13'd4096;
    localparam logic [COL_W-1:0] STEAL_UNIT = 13'd16;

    localparam logic [COL_W-1:0] IMAGE_WIDTH_RST = 13'd64;
    localparam logic [WID_W-1:0] WORKER_COUNT_RST = 4'd4;
    localparam logic [COL_W-1:0] STEAL_THRESHOLD_RST = 13'(2 * STEAL_UNIT);

    localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_WIDTH = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_WORKER_COUNT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_STEAL_THRESHOLD = 2'd2;

    typedef enum logic [OPC_W-1:0] {
        OP_START  = 2'd0,
        OP_UPDATE = 2'd1,
        OP_GET    = 2'd2,
        OP_NOP    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_SCAN,
        S_DONE
    } state_t;

    // Operation broadcast to every cell while a token walks the chain.
    typedef struct packed {
        op_t              op;
        logic [WID_W-1:0] me;
        logic             me_ok;
        logic [COL_W-1:0] ns;
        logic [COL_W-1:0] ne;
        logic [WID_W-1:0] cnt;
        logic [COL_W-1:0] thr;
    } ctl_t;

    // Token handed from one cell to the next, one cell per cycle.
    typedef struct packed {
        logic             valid;
        logic [COL_W-1:0] acc;
        logic             own_has;
        logic [COL_W-1:0] own_s;
        logic [COL_W-1:0] own_e;
        logic             found;
        logic [WID_W-1:0] vic_idx;
        logic [COL_W-1:0] vic_end;
        logic [COL_W-1:0] half;
        logic             busy;
    } tok_t;

    // Steal commit broadcast once the token has left the last cell.
    typedef struct packed {
        logic             en;
        logic [WID_W-1:0] vic_idx;
        logic [COL_W-1:0] vic_end_new;
        logic [WID_W-1:0] me;
        logic [COL_W-1:0] me_s;
        logic [COL_W-1:0] me_e;
    } cmt_t;

    function automatic logic [COL_W-1:0] sat_col(input logic [COL_W-1:0] v);
        return (v > MAX_COLUMNS) ? MAX_COLUMNS : v;
    endfunction

    function automatic logic [COL_W-1:0] work_left(input logic [COL_W-1:0] s,
                                                   input logic [COL_W-1:0] e);
        return (e > s) ? (e - s) : '0;
    endfunction

endpackage

`default_nettype wire

### src/wrss_ifs.sv
// Request and response channel interfaces of the work range stealing scheduler.
`default_nettype none

interface wrss_req_if;
    import wrss_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [OPC_W-1:0]     opcode;
    logic [WID_W-1:0]     worker_id;
    logic [COL_W-1:0]     new_start;
    logic [COL_W-1:0]     new_end;

    modport source (output valid, opcode, worker_id, new_start, new_end, input ready);
    modport sink   (input valid, opcode, worker_id, new_start, new_end, output ready);
endinterface

interface wrss_rsp_if;
    import wrss_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 granted;
    logic [COL_W-1:0]     range_start;
    logic [COL_W-1:0]     range_end;
    logic                 all_done;

    modport source (output valid, granted, range_start, range_end, all_done, input ready);
    modport sink   (input valid, granted, range_start, range_end, all_done, output ready);
endinterface

`default_nettype wire

### src/wrss_div.sv
// Bit-serial restoring divider that computes the per-worker column count.
`default_nettype none

module wrss_div (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [wrss_pkg::COL_W-1:0] dividend,
    input  logic [wrss_pkg::WID_W-1:0] divisor,
    output logic                    done,
    output logic [wrss_pkg::COL_W-1:0] quotient
);
    import wrss_pkg::*;

    localparam int STEP_W = $clog2(COL_W + 1);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(COL_W - 1);

    logic [COL_W-1:0]  quo_reg, quo_next;
    logic [WID_W-1:0]  rem_reg, rem_next;
    logic [WID_W-1:0]  dvs_reg, dvs_next;
    logic [STEP_W-1:0] count_reg, count_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [WID_W:0]    shifted;
    logic [WID_W:0]    diff;
    logic              fits;

    assign shifted = {rem_reg, quo_reg[COL_W-1]};
    assign fits    = shifted >= {1'b0, dvs_reg};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        count_next = count_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            quo_next   = dividend;
            rem_next   = '0;
            dvs_next   = divisor;
            count_next = '0;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            // The remainder stays below the divisor, so it fits in the divisor's width.
            rem_next   = fits ? diff[WID_W-1:0] : shifted[WID_W-1:0];
            quo_next   = {quo_reg[COL_W-2:0], fits};
            count_next = count_reg + 1'b1;
            if (count_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

### src/wrss_cell.sv
// One worker slot of the range table; it updates its range and forwards the scan token.
`default_nettype none

module wrss_cell #(
    parameter int IDX = 0
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  wrss_pkg::ctl_t             ctl,
    input  logic [wrss_pkg::COL_W-1:0] step,
    input  wrss_pkg::cmt_t             cmt,
    input  wrss_pkg::tok_t             tok_in,
    output wrss_pkg::tok_t             tok_out
);
    import wrss_pkg::*;

    logic [COL_W-1:0] start_reg, start_next;
    logic [COL_W-1:0] end_reg, end_next;
    tok_t             tok_reg, tok_next;
    logic             in_use;
    logic             is_me;
    logic [COL_W-1:0] work;
    logic [COL_W-1:0] upd_work;
    logic [COL_W-1:0] sum;

    assign in_use   = IDX < int'(ctl.cnt);
    assign is_me    = ctl.me_ok && (int'(ctl.me) == IDX);
    assign work     = work_left(start_reg, end_reg);
    assign upd_work = is_me ? work_left(ctl.ns, ctl.ne) : work;
    assign sum      = tok_in.acc + step;

    always_comb
    begin
        start_next = start_reg;
        end_next   = end_reg;
        tok_next   = tok_in;
        if (tok_in.valid)
        begin
            unique case (ctl.op)
                OP_START:
                begin
                    if (in_use)
                    begin
                        start_next    = tok_in.acc;
                        end_next      = sum;
                        tok_next.acc  = sum;
                        tok_next.busy = tok_in.busy | (step != '0);
                    end
                    else
                    begin
                        start_next = '0;
                        end_next   = '0;
                    end
                end
                OP_UPDATE:
                begin
                    if (is_me)
                    begin
                        start_next = ctl.ns;
                        end_next   = ctl.ne;
                    end
                    if (in_use)
                    begin
                        tok_next.busy = tok_in.busy | (upd_work != '0);
                    end
                end
                OP_GET:
                begin
                    if (in_use)
                    begin
                        tok_next.busy = tok_in.busy | (work != '0);
                        if (is_me)
                        begin
                            tok_next.own_has = work != '0;
                            tok_next.own_s   = start_reg;
                            tok_next.own_e   = end_reg;
                        end
                        // The lowest eligible victim wins; later cells see found set.
                        if (!tok_in.found && work != '0 && work >= ctl.thr)
                        begin
                            tok_next.found   = 1'b1;
                            tok_next.vic_idx = WID_W'(IDX);
                            tok_next.vic_end = end_reg;
                            tok_next.half    = {1'b0, work[COL_W-1:1]};
                        end
                    end
                end
                OP_NOP:
                begin
                    if (in_use)
                    begin
                        tok_next.busy = tok_in.busy | (work != '0);
                    end
                end
            endcase
        end
        if (cmt.en)
        begin
            if (int'(cmt.vic_idx) == IDX)
            begin
                end_next = cmt.vic_end_new;
            end
            if (int'(cmt.me) == IDX)
            begin
                start_next = cmt.me_s;
                end_next   = cmt.me_e;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            end_reg   <= '0;
            tok_reg   <= '0;
        end
        else
        begin
            start_reg <= start_next;
            end_reg   <= end_next;
            tok_reg   <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

### src/work_range_stealing_scheduler.sv
// Top level of the work range stealing scheduler: control, configuration and the cell chain.
//
//   channel | direction | transfer                         | payload
//   --------+-----------+----------------------------------+--------------------------------------
//   req     | in        | valid & ready at rising clk      | opcode, worker_id, new_start, new_end
//   rsp     | out       | valid & ready at rising clk      | granted, range_start, range_end, all_done
//   cfg     | in        | cfg_wr_en at rising clk          | cfg_addr, cfg_wdata
//
// A scan token walks the cell chain one cell per cycle; for update, get and unused opcodes it is
// launched on acceptance and the result is registered once it leaves the last cell; start first runs the
// bit-serial divider that computes the per-worker column count.
// Reset clears the range table to zero and loads the register defaults at once.
// The response register holds a finished transaction while the next request is accepted; a
// further result waits in the done state until the response is taken.
`default_nettype none

module work_range_stealing_scheduler (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [wrss_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [wrss_pkg::COL_W-1:0]      cfg_wdata,
    wrss_req_if.sink                        req,
    wrss_rsp_if.source                      rsp
);
    import wrss_pkg::*;

    state_t           state_reg, state_next;
    logic [COL_W-1:0] image_width_reg;
    logic [WID_W-1:0] worker_count_reg;
    logic [COL_W-1:0] steal_threshold_reg;
    logic [WID_W-1:0] cnt;
    op_t              req_op;
    logic             in_ready;
    logic             accept;
    logic             div_start;
    logic             div_done;
    logic [COL_W-1:0] div_quo;
    logic             launch;
    logic             capture;
    logic             load_out;
    ctl_t             ctl_reg;
    tok_t             tok0_reg, tok0_next;
    tok_t             tok_src [MAX_WORKERS];
    tok_t             chain [MAX_WORKERS];
    tok_t             tail;
    logic [MAX_WORKERS-1:0] chain_valid;
    cmt_t             cmt;
    logic             steal_ok;
    logic [COL_W-1:0] steal_start;
    logic             res_granted_reg;
    logic [COL_W-1:0] res_start_reg;
    logic [COL_W-1:0] res_end_reg;
    logic             res_done_reg;
    logic             rsp_valid_reg;
    logic             rsp_granted_reg;
    logic [COL_W-1:0] rsp_start_reg;
    logic [COL_W-1:0] rsp_end_reg;
    logic             rsp_done_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg     <= IMAGE_WIDTH_RST;
            worker_count_reg    <= WORKER_COUNT_RST;
            steal_threshold_reg <= STEAL_THRESHOLD_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                CFG_IMAGE_WIDTH:     image_width_reg     <= cfg_wdata;
                CFG_WORKER_COUNT:    worker_count_reg    <= cfg_wdata[WID_W-1:0];
                CFG_STEAL_THRESHOLD: steal_threshold_reg <= cfg_wdata;
                default:             ;
            endcase
        end
    end

    // Workers in use: zero counts as one, and the count saturates at the table size.
    always_comb
    begin
        priority if (worker_count_reg == '0)
            cnt = WID_W'(1);
        else if (int'(worker_count_reg) > MAX_WORKERS)
            cnt = WID_W'(MAX_WORKERS);
        else
            cnt = worker_count_reg;
    end

    assign req_op = op_t'(req.opcode);
    assign tail   = chain[MAX_WORKERS-1];

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                    state_next = (req_op == OP_START) ? S_DIV : S_SCAN;
            end
            S_DIV:
            begin
                if (div_done)
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (tail.valid)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                    state_next = S_IDLE;
            end
        endcase
    end

    // Control outputs.
    always_comb
    begin
        in_ready  = state_reg == S_IDLE;
        accept    = in_ready && req.valid;
        div_start = accept && req_op == OP_START;
        launch    = (accept && req_op != OP_START) || (state_reg == S_DIV && div_done);
        capture   = state_reg == S_SCAN && tail.valid;
        load_out  = state_reg == S_DONE && (!rsp_valid_reg || rsp.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign req.ready = in_ready;

    // Operation held for the whole walk of the token.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ctl_reg.op    <= req_op;
            ctl_reg.me    <= req.worker_id - 1'b1;
            ctl_reg.me_ok <= req.worker_id != '0 && req.worker_id <= cnt;
            ctl_reg.ns    <= sat_col(req.new_start);
            ctl_reg.ne    <= sat_col(req.new_end);
            ctl_reg.cnt   <= cnt;
            ctl_reg.thr   <= steal_threshold_reg;
        end
    end

    wrss_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sat_col(image_width_reg)),
        .divisor  (cnt),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        tok0_next       = '0;
        tok0_next.valid = launch;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok0_reg <= '0;
        end
        else
        begin
            tok0_reg <= tok0_next;
        end
    end

    assign tok_src[0] = tok0_reg;

    generate
        for (genvar k = 0; k < MAX_WORKERS; k++)
        begin : g_cell
            if (k > 0)
            begin : g_link
                assign tok_src[k] = chain[k-1];
            end
            assign chain_valid[k] = chain[k].valid;
            wrss_cell #(.IDX(k)) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctl     (ctl_reg),
                .step    (div_quo),
                .cmt     (cmt),
                .tok_in  (tok_src[k]),
                .tok_out (chain[k])
            );
        end
    endgenerate

    // The requester takes the upper half of the victim when its own range is empty.
    assign steal_ok    = ctl_reg.op == OP_GET && ctl_reg.me_ok && !tail.own_has && tail.found;
    assign steal_start = tail.vic_end - tail.half;

    always_comb
    begin
        cmt.en          = capture && steal_ok;
        cmt.vic_idx     = tail.vic_idx;
        cmt.vic_end_new = steal_start;
        cmt.me          = ctl_reg.me;
        cmt.me_s        = steal_start;
        cmt.me_e        = tail.vic_end;
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            // A steal leaves work with the victim, so all_done is unchanged by it.
            res_done_reg <= !tail.busy;
            priority if (ctl_reg.op == OP_GET && ctl_reg.me_ok && tail.own_has)
            begin
                res_granted_reg <= 1'b1;
                res_start_reg   <= tail.own_s;
                res_end_reg     <= tail.own_e;
            end
            else if (steal_ok && tail.half != '0)
            begin
                res_granted_reg <= 1'b1;
                res_start_reg   <= steal_start;
                res_end_reg     <= tail.vic_end;
            end
            else
            begin
                res_granted_reg <= 1'b0;
                res_start_reg   <= '0;
                res_end_reg     <= '0;
            end
        end
    end

    // Response register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (load_out)
            rsp_valid_reg <= 1'b1;
        else if (rsp.ready)
            rsp_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            rsp_granted_reg <= res_granted_reg;
            rsp_start_reg   <= res_start_reg;
            rsp_end_reg     <= res_end_reg;
            rsp_done_reg    <= res_done_reg;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.granted     = rsp_granted_reg;
    assign rsp.range_start = rsp_start_reg;
    assign rsp.range_end   = rsp_end_reg;
    assign rsp.all_done    = rsp_done_reg;

`ifndef SYNTHESIS
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(chain_valid))
        else $error("more than one scan token in the cell chain");

    a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        tail.valid |-> state_reg == S_SCAN)
        else $error("scan token left the chain outside the scan state");

    a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside the divide state");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != S_IDLE)
        else $error("accepted transaction did not start");

    a_grant_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_granted_reg |-> rsp_end_reg > rsp_start_reg)
        else $error("granted range is empty");
`endif

endmodule

`default_nettype wire

### bench/wrss_checker.sv
// Checker for the work range stealing scheduler: watches its ports, predicts each response and compares.
module wrss_checker
    import wrss_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [COL_W-1:0]      cfg_wdata,
    wrss_req_if                   req,
    wrss_rsp_if                   rsp,
    output int                    mismatches,
    output int                    outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SLOTS = 8;

    typedef struct packed {
        logic             granted;
        logic [COL_W-1:0] range_start;
        logic [COL_W-1:0] range_end;
        logic             all_done;
    } grant_t;

    logic [COL_W-1:0] col_lo [SLOTS];
    logic [COL_W-1:0] col_hi [SLOTS];
    logic [COL_W-1:0] width_reg;
    logic [WID_W-1:0] count_reg;
    logic [COL_W-1:0] thresh_reg;

    grant_t expected_grants [$];

    function automatic int unsigned clamp_col(input logic [COL_W-1:0] v);
        return (v > MAX_COLUMNS) ? MAX_COLUMNS : v;
    endfunction

    function automatic int unsigned workers_in_use();
        if (count_reg == 0)
            return 1;
        return (count_reg > SLOTS) ? SLOTS : count_reg;
    endfunction

    function automatic int unsigned cols_left(input int unsigned idx);
        return (col_hi[idx] > col_lo[idx]) ? col_hi[idx] - col_lo[idx] : 0;
    endfunction

    // Applies one request to the range table and returns the response it produces.
    function automatic grant_t serve_request(input logic [OPC_W-1:0] opc,
                                             input logic [WID_W-1:0] id,
                                             input logic [COL_W-1:0] ns_in,
                                             input logic [COL_W-1:0] ne_in);
        grant_t      r;
        int unsigned n, share, me, w, half, i;
        bit          id_ok, have, found;
        r = '0;
        n = workers_in_use();
        id_ok = (id >= 1) && (id <= n);
        case (opc)
            OP_START:
            begin
                share = clamp_col(width_reg) / n;
                for (i = 0; i < SLOTS; i++)
                begin
                    col_lo[i] = (i < n) ? i * share : 0;
                    col_hi[i] = (i < n) ? (i + 1) * share : 0;
                end
            end
            OP_UPDATE:
            begin
                if (id_ok)
                begin
                    col_lo[id - 1] = clamp_col(ns_in);
                    col_hi[id - 1] = clamp_col(ne_in);
                end
            end
            OP_GET:
            begin
                if (id_ok)
                begin
                    me = id - 1;
                    have = cols_left(me) > 0;
                    found = 1'b0;
                    // An idle requester takes the upper half of the first range that is big enough.
                    for (i = 0; i < n && !have && !found; i++)
                    begin
                        w = cols_left(i);
                        if (w > 0 && w >= thresh_reg)
                        begin
                            half = w / 2;
                            col_lo[me] = col_hi[i] - half;
                            col_hi[me] = col_hi[i];
                            col_hi[i] = col_hi[i] - half;
                            have = cols_left(me) > 0;
                            found = 1'b1;
                        end
                    end
                    if (have)
                    begin
                        r.granted = 1'b1;
                        r.range_start = col_lo[me];
                        r.range_end = col_hi[me];
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.all_done = 1'b1;
        for (i = 0; i < n; i++)
            if (cols_left(i) > 0)
                r.all_done = 1'b0;
        return r;
    endfunction

    task automatic note_mismatch(input string field, input logic [COL_W-1:0] want,
                                 input logic [COL_W-1:0] got);
        mismatches++;
        $error("%s: expected %0d, actual %0d", field, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        grant_t want;
        if (!rst_n)
        begin
            for (int k = 0; k < SLOTS; k++)
            begin
                col_lo[k] = '0;
                col_hi[k] = '0;
            end
            width_reg = IMAGE_WIDTH_RST;
            count_reg = WORKER_COUNT_RST;
            thresh_reg = STEAL_THRESHOLD_RST;
            expected_grants.delete();
            outstanding = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_addr)
                    CFG_IMAGE_WIDTH:     width_reg = cfg_wdata;
                    CFG_WORKER_COUNT:    count_reg = cfg_wdata[WID_W-1:0];
                    CFG_STEAL_THRESHOLD: thresh_reg = cfg_wdata;
                    default:
                    begin
                    end
                endcase
            end
            if (rsp.valid && rsp.ready)
            begin
                if (expected_grants.size() == 0)
                begin
                    mismatches++;
                    $error("response transaction with no request outstanding");
                end
                else
                begin
                    want = expected_grants.pop_front();
                    if (rsp.granted !== want.granted)
                        note_mismatch("granted", want.granted, rsp.granted);
                    if (rsp.range_start !== want.range_start)
                        note_mismatch("range_start", want.range_start, rsp.range_start);
                    if (rsp.range_end !== want.range_end)
                        note_mismatch("range_end", want.range_end, rsp.range_end);
                    if (rsp.all_done !== want.all_done)
                        note_mismatch("all_done", want.all_done, rsp.all_done);
                end
            end
            if (req.valid && req.ready)
                expected_grants.insert(expected_grants.size(),
                                       serve_request(req.opcode, req.worker_id,
                                                     req.new_start, req.new_end));
            outstanding = expected_grants.size();
        end
    end

    initial mismatches = 0;

endmodule

### bench/work_range_stealing_scheduler_tb.sv
// Testbench top of the work range stealing scheduler: clock, reset, stimulus and verdict.
module work_range_stealing_scheduler_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import wrss_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int RANDOM_ITEMS = 1250;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [COL_W-1:0]      cfg_wdata;
    int                    mismatches;
    int                    outstanding;
    int                    cycles = 0;
    bit                    calm;
    int                    active_workers;
    int                    cur_cols;

    wrss_req_if req_ch ();
    wrss_rsp_if rsp_ch ();

    work_range_stealing_scheduler uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    wrss_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("work_range_stealing_scheduler: mismatch");
            $finish;
        end
    end

    // Sends one request transaction; called and returning at a falling edge.
    task automatic issue(input op_t op, input int id, input int ns, input int ne);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.opcode <= op;
        req_ch.worker_id <= id[WID_W-1:0];
        req_ch.new_start <= ns[COL_W-1:0];
        req_ch.new_end <= ne[COL_W-1:0];
        do
            @(posedge clk);
        while (!req_ch.ready);
        @(negedge clk);
    endtask

    task automatic issue_update(input int id);
        int kind, lo, hi;
        kind = $urandom_range(0, 9);
        lo = $urandom_range(0, cur_cols);
        if (kind < 4)
            hi = lo;
        else if (kind < 7)
            hi = lo + $urandom_range(1, 64 + cur_cols / 2);
        else if (kind == 7)
        begin
            hi = lo;
            lo = hi + $urandom_range(1, 100);
        end
        else if (kind == 8)
        begin
            lo = $urandom_range(0, 8191);
            hi = $urandom_range(0, 8191);
        end
        else
        begin
            lo = 0;
            hi = $urandom_range(0, 8191);
        end
        issue(OP_UPDATE, id, lo, hi);
    endtask

    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        wait (outstanding == 0);
        repeat (2) @(negedge clk);
    endtask

    task automatic configure(input int cols, input int workers, input int thresh);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_addr <= CFG_IMAGE_WIDTH;
        cfg_wdata <= cols[COL_W-1:0];
        @(negedge clk);
        cfg_addr <= CFG_WORKER_COUNT;
        cfg_wdata <= workers[COL_W-1:0];
        @(negedge clk);
        cfg_addr <= CFG_STEAL_THRESHOLD;
        cfg_wdata <= thresh[COL_W-1:0];
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        cur_cols = (cols > MAX_COLUMNS) ? MAX_COLUMNS : cols;
        active_workers = (workers == 0) ? 1 : ((workers > 8) ? 8 : workers);
    endtask

    // A partition followed by mostly well-formed requests from workers in use.
    task automatic run_phase(input int n_items);
        int done_items, pick, id, col;
        done_items = 0;
        issue(OP_START, $urandom_range(0, 15), $urandom_range(0, 8191),
              $urandom_range(0, 8191));
        while (done_items < n_items)
        begin
            pick = $urandom_range(0, 99);
            id = $urandom_range(1, active_workers);
            if (pick < 55)
                issue(OP_GET, id, $urandom_range(0, 8191), $urandom_range(0, 8191));
            else if (pick < 80)
                issue_update(id);
            else if (pick < 84)
                issue(OP_START, id, 0, 0);
            else
                issue(op_t'($urandom_range(0, 3)), $urandom_range(0, 15),
                      $urandom_range(0, 8191), $urandom_range(0, 8191));
            done_items++;
        end
        // Sometimes every worker reports its range finished, so the table drains to all done.
        if ($urandom_range(0, 1))
        begin
            for (id = 1; id <= active_workers; id++)
            begin
                col = $urandom_range(0, cur_cols);
                issue(OP_UPDATE, id, col, col);
            end
            issue(OP_GET, $urandom_range(1, active_workers), 0, 0);
        end
    endtask

    initial
    begin
        int stall;
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, 17);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(rsp_ch.valid && rsp_ch.ready));
            @(negedge clk);
        end
    end

    initial
    begin
        int issued, n_items, w, c, t;
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr = CFG_IMAGE_WIDTH;
        cfg_wdata = '0;
        req_ch.valid = 1'b0;
        req_ch.opcode = OP_NOP;
        req_ch.worker_id = '0;
        req_ch.new_start = '0;
        req_ch.new_end = '0;
        calm = 1'b0;
        active_workers = WORKER_COUNT_RST;
        cur_cols = IMAGE_WIDTH_RST;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Default registers: empty table, partition, refusal below threshold, a steal,
        // bad worker ids, the unused opcode, saturated and reversed updates.
        issue(OP_GET, 1, 0, 0);
        issue(OP_START, 0, 0, 0);
        issue(OP_GET, 1, 0, 0);
        issue(OP_UPDATE, 1, 16, 16);
        issue(OP_GET, 1, 0, 0);
        issue(OP_UPDATE, 2, 16, 80);
        issue(OP_GET, 1, 0, 0);
        issue(OP_GET, 0, 0, 0);
        issue(OP_GET, 5, 0, 0);
        issue(OP_UPDATE, 15, 8191, 8191);
        issue(OP_NOP, 3, 8191, 8191);
        issue(OP_UPDATE, 3, 8191, 8191);
        issue(OP_UPDATE, 4, 5000, 100);
        issue(OP_GET, 4, 0, 0);

        // Oversized width, a worker count of zero and a zero threshold.
        configure(8191, 0, 0);
        issue(OP_START, 0, 0, 0);
        issue(OP_UPDATE, 1, 5, 5);
        issue(OP_GET, 1, 0, 0);

        // Width below the worker count, an oversized count, and a one-column victim.
        configure(1, 15, 1);
        issue(OP_START, 0, 0, 0);
        issue(OP_UPDATE, 2, 7, 8);
        issue(OP_GET, 3, 0, 0);

        // Widest table with a threshold equal to the full width.
        configure(4096, 8, 4096);
        issue(OP_START, 0, 0, 0);
        issue(OP_UPDATE, 1, 0, 0);
        issue(OP_GET, 1, 0, 0);
        issue(OP_UPDATE, 2, 0, 4096);
        issue(OP_GET, 1, 0, 0);

        issued = 0;
        while (issued < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 5))
                0:       w = 1;
                1:       w = 4096;
                2:       w = $urandom_range(4097, 8191);
                default: w = $urandom_range(1, 4096);
            endcase
            c = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
            case ($urandom_range(0, 7))
                0:       t = 0;
                1:       t = 1;
                2:       t = 4096;
                3:       t = $urandom_range(4097, 8191);
                default: t = $urandom_range(2, 64);
            endcase
            configure(w, c, t);
            calm = ($urandom_range(0, 4) == 0);
            n_items = $urandom_range(40, 120);
            run_phase(n_items);
            issued += n_items;
        end

        wait_idle();
        repeat (40) @(negedge clk);
        if (mismatches == 0)
            $display("work_range_stealing_scheduler: match");
        else
            $display("work_range_stealing_scheduler: mismatch");
        $finish;
    end

endmodule
